// File: design/bole_pkg.sv
package bole_pkg;

   // list geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int EXT_W  = (CNT_W > 7) ? CNT_W : 7;

   // field widths of the stream payloads
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int IDX_W   = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [EXT_W-1:0]  ext_type;

   // operation kinds
   localparam logic [KIND_W-1:0] K_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] K_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] K_POP    = 2'd2;
   localparam logic [KIND_W-1:0] K_FIND   = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   localparam logic [IDX_W-1:0] IDX_NONE = 7'h7F;

   // controller to datapath
   typedef struct packed {
      logic              latch;      // capture request value, reset found index
      logic              append_wr;
      logic              occ_inc;
      logic              occ_dec;
      logic              ptr_clr;
      logic              ptr_pos;    // pointer to entry after the removed one
      logic              ptr_inc;
      logic              shift_wr;
      logic              found_set;
      logic              status_set;
      logic [STAT_W-1:0] status;
      logic              out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              empty;
      logic              pos_bad;
      logic              pos_last;
      logic              ptr_last;
      logic              hit;
      logic              out_free;
   } sts_type;

endpackage

// File: design/bounded_ordered_list_engine.sv
// bounded ordered list engine
// holds an ordered list of up to bole_pkg::DEPTH signed 32-bit values in one ram
// req channel: one transfer per operation; req_tuser carries the kind
//   (append, remove at position, pop last, find first), req_tdata the value
//   and the position
// rsp channel: exactly one transfer per operation with status, found index
//   (-1 unless a find hits), entry count after the operation and empty flag
// one operation is worked on at a time; req_tready is high only while idle
// work done after a req transfer:
//   append, pop and any rejected operation: go straight to the result
//   remove at position p: entries behind p move down, one ram shift per cycle
//   find: scans from index 0 up to the first hit or the end of the list
// the ram has one write and one registered read port, so shifts and scans
// move one entry per cycle
// the result sits in an output register, so the next operation is taken
// while an earlier result still waits for rsp_tready; a stalled receiver
// only holds the engine once a second result is ready
// reset clears the entry count and the result valid flag and sends the
// controller to idle; ram contents are left as they are
module bounded_ordered_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // item_value [31:0], position [37:32], zero pad
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status [1:0], found_index [8:2],
                                    // entry_count [15:9], is_empty [16], zero pad
);

   bole_pkg::cmd_type cmd;
   bole_pkg::sts_type sts;

   // sequencing of accept, shift, scan and result load
   bole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // entry ram, count, pointer and result register
   bole_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: design/bole_ram.sv
module bole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bole_ctrl.sv
module bole_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bole_pkg::sts_type sts,
   output bole_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch      = 1'b1;
               cmd.status_set = 1'b1;
               cmd.status     = bole_pkg::ST_OK;
               state_in       = S_RESP;
               unique case (sts.kind)
                  bole_pkg::K_APPEND: begin
                     if (sts.full) begin
                        cmd.status = bole_pkg::ST_FULL;
                     end else begin
                        cmd.append_wr = 1'b1;
                        cmd.occ_inc   = 1'b1;
                     end
                  end
                  bole_pkg::K_REMOVE: begin
                     if (sts.pos_bad) begin
                        cmd.status = bole_pkg::ST_RANGE;
                     end else if (sts.pos_last) begin
                        cmd.occ_dec = 1'b1;
                     end else begin
                        cmd.ptr_pos = 1'b1;
                        state_in    = S_SHIFT;
                     end
                  end
                  bole_pkg::K_POP: begin
                     if (sts.empty) begin
                        cmd.status = bole_pkg::ST_RANGE;
                     end else begin
                        cmd.occ_dec = 1'b1;
                     end
                  end
                  bole_pkg::K_FIND: begin
                     cmd.status = bole_pkg::ST_NOTFOUND;
                     if (!sts.empty) begin
                        cmd.ptr_clr = 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SHIFT: begin
            cmd.shift_wr = 1'b1;
            if (sts.ptr_last) begin
               cmd.occ_dec = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               cmd.found_set  = 1'b1;
               cmd.status_set = 1'b1;
               cmd.status     = bole_pkg::ST_OK;
               state_in       = S_RESP;
            end else if (sts.ptr_last) begin
               state_in = S_RESP;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/bole_dp.sv
module bole_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bole_pkg::KIND_W-1:0]         req_tuser,
   input  logic [bole_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [bole_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  bole_pkg::cmd_type                   cmd,
   output bole_pkg::sts_type                   sts
);

   logic [bole_pkg::VALUE_W-1:0] req_value;
   logic [bole_pkg::POS_W-1:0]   req_pos;

   logic [bole_pkg::VALUE_W-1:0] value_ff;
   bole_pkg::cnt_type            occ_ff;
   bole_pkg::cnt_type            occ_in;
   bole_pkg::cnt_type            ptr_ff;
   bole_pkg::cnt_type            ptr_in;
   bole_pkg::cnt_type            ptr_m1;
   logic [bole_pkg::STAT_W-1:0]  status_ff;
   logic [bole_pkg::IDX_W-1:0]   found_ff;
   logic                         rsp_valid_ff;
   logic [bole_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   bole_pkg::ext_type occ_x;
   bole_pkg::ext_type ptr_x;
   bole_pkg::ext_type pos_x;

   logic                         wr_en;
   bole_pkg::addr_type           wr_addr;
   logic [bole_pkg::VALUE_W-1:0] wr_data;
   logic [bole_pkg::VALUE_W-1:0] rd_data;

   assign req_value = req_tdata[31:0];
   assign req_pos   = req_tdata[37:32];

   assign occ_x  = bole_pkg::ext_type'(occ_ff);
   assign ptr_x  = bole_pkg::ext_type'(ptr_ff);
   assign pos_x  = bole_pkg::ext_type'(req_pos);
   assign ptr_m1 = ptr_ff - bole_pkg::cnt_type'(1);

   always_comb begin
      sts          = '0;
      sts.kind     = req_tuser;
      sts.full     = (occ_x >= bole_pkg::ext_type'(bole_pkg::DEPTH));
      sts.empty    = (occ_ff == '0);
      sts.pos_bad  = (pos_x >= occ_x);
      sts.pos_last = ((pos_x + bole_pkg::ext_type'(1)) == occ_x);
      sts.ptr_last = ((ptr_x + bole_pkg::ext_type'(1)) == occ_x);
      sts.hit      = (rd_data == value_ff);
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   // list pointer; its next value drives the memory read address, so read data matches the registered pointer
   always_comb begin
      priority if (cmd.ptr_clr) begin
         ptr_in = '0;
      end else if (cmd.ptr_pos) begin
         ptr_in = bole_pkg::cnt_type'(pos_x + bole_pkg::ext_type'(1));
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + bole_pkg::cnt_type'(1);
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_comb begin
      priority if (cmd.occ_inc) begin
         occ_in = occ_ff + bole_pkg::cnt_type'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - bole_pkg::cnt_type'(1);
      end else begin
         occ_in = occ_ff;
      end
   end

   assign wr_en   = cmd.append_wr || cmd.shift_wr;
   assign wr_addr = cmd.shift_wr ? ptr_m1[bole_pkg::ADDR_W-1:0]
                                 : occ_ff[bole_pkg::ADDR_W-1:0];
   assign wr_data = cmd.shift_wr ? rd_data : req_value;

   bole_ram #(
      .WIDTH (bole_pkg::VALUE_W),
      .DEPTH (bole_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_in[bole_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.latch) begin
         value_ff <= req_value;
         found_ff <= bole_pkg::IDX_NONE;
      end
      if (cmd.found_set) begin
         found_ff <= ptr_x[bole_pkg::IDX_W-1:0];
      end
      if (cmd.status_set) begin
         status_ff <= cmd.status;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {7'd0, (occ_ff == '0), occ_x[bole_pkg::IDX_W-1:0],
                         found_ff, status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_x <= bole_pkg::ext_type'(bole_pkg::DEPTH))
      else $error("occupancy above list depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> (ptr_ff != '0) && (ptr_x < occ_x))
      else $error("shift outside the held entries");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.occ_inc |=> (occ_ff == $past(occ_ff) + bole_pkg::cnt_type'(1)))
      else $error("append did not grow the list by one");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   // expected content of one rsp transfer
   typedef struct packed {
      logic [bole_pkg::STAT_W-1:0] status;
      logic [bole_pkg::IDX_W-1:0]  found_index;
      logic [6:0]                  entry_count;
      logic                        is_empty;
   } list_result_type;

   // one row of the directed table; has_result marks rows whose result is typed in
   typedef struct packed {
      logic [bole_pkg::KIND_W-1:0]  kind;
      logic [bole_pkg::VALUE_W-1:0] item_value;
      logic [bole_pkg::POS_W-1:0]   position;
      logic                         has_result;
      list_result_type              result;
   } op_row_type;

   localparam int NUM_DIRECTED = 25;
   localparam int NUM_RANDOM   = 550;
   localparam int MAX_WAIT     = 18;

   // regimes of the random part
   localparam int GROW  = 0;
   localparam int SHRINK = 1;
   localparam int MIXED = 2;

   localparam list_result_type NONE_ROW =
      '{bole_pkg::ST_OK, bole_pkg::IDX_NONE, 7'd0, 1'b0};

   // directed part: empty-list errors, field extremes, duplicates, out of
   // range removes, head, tail and middle removes, pops back down to empty
   localparam op_row_type DIRECTED_OPS [NUM_DIRECTED] = '{
      '{bole_pkg::K_POP,    32'h0000_0000, 6'd0,  1'b1,
        '{bole_pkg::ST_RANGE,    bole_pkg::IDX_NONE, 7'd0, 1'b1}},
      '{bole_pkg::K_REMOVE, 32'h0000_0000, 6'd0,  1'b1,
        '{bole_pkg::ST_RANGE,    bole_pkg::IDX_NONE, 7'd0, 1'b1}},
      '{bole_pkg::K_REMOVE, 32'hFFFF_FFFF, 6'd63, 1'b1,
        '{bole_pkg::ST_RANGE,    bole_pkg::IDX_NONE, 7'd0, 1'b1}},
      '{bole_pkg::K_FIND,   32'h0000_0000, 6'd0,  1'b1,
        '{bole_pkg::ST_NOTFOUND, bole_pkg::IDX_NONE, 7'd0, 1'b1}},
      '{bole_pkg::K_APPEND, 32'h7FFF_FFFF, 6'd0,  1'b1,
        '{bole_pkg::ST_OK,       bole_pkg::IDX_NONE, 7'd1, 1'b0}},
      '{bole_pkg::K_APPEND, 32'h8000_0000, 6'd63, 1'b1,
        '{bole_pkg::ST_OK,       bole_pkg::IDX_NONE, 7'd2, 1'b0}},
      '{bole_pkg::K_APPEND, 32'h0000_0000, 6'd0,  1'b1,
        '{bole_pkg::ST_OK,       bole_pkg::IDX_NONE, 7'd3, 1'b0}},
      '{bole_pkg::K_APPEND, 32'hFFFF_FFFF, 6'd0,  1'b1,
        '{bole_pkg::ST_OK,       bole_pkg::IDX_NONE, 7'd4, 1'b0}},
      '{bole_pkg::K_APPEND, 32'h7FFF_FFFF, 6'd0,  1'b1,
        '{bole_pkg::ST_OK,       bole_pkg::IDX_NONE, 7'd5, 1'b0}},
      '{bole_pkg::K_FIND,   32'h7FFF_FFFF, 6'd0,  1'b0, NONE_ROW},
      '{bole_pkg::K_FIND,   32'h8000_0000, 6'd63, 1'b0, NONE_ROW},
      '{bole_pkg::K_FIND,   32'hFFFF_FFFF, 6'd0,  1'b0, NONE_ROW},
      '{bole_pkg::K_FIND,   32'h1234_5678, 6'd0,  1'b1,
        '{bole_pkg::ST_NOTFOUND, bole_pkg::IDX_NONE, 7'd5, 1'b0}},
      '{bole_pkg::K_REMOVE, 32'h0000_0000, 6'd5,  1'b1,
        '{bole_pkg::ST_RANGE,    bole_pkg::IDX_NONE, 7'd5, 1'b0}},
      '{bole_pkg::K_REMOVE, 32'h5555_5555, 6'd63, 1'b1,
        '{bole_pkg::ST_RANGE,    bole_pkg::IDX_NONE, 7'd5, 1'b0}},
      '{bole_pkg::K_REMOVE, 32'h0000_0000, 6'd0,  1'b0, NONE_ROW},
      '{bole_pkg::K_FIND,   32'h7FFF_FFFF, 6'd0,  1'b0, NONE_ROW},
      '{bole_pkg::K_REMOVE, 32'h0000_0000, 6'd3,  1'b0, NONE_ROW},
      '{bole_pkg::K_REMOVE, 32'hAAAA_AAAA, 6'd1,  1'b0, NONE_ROW},
      '{bole_pkg::K_APPEND, 32'hAAAA_AAAA, 6'd63, 1'b0, NONE_ROW},
      '{bole_pkg::K_FIND,   32'hAAAA_AAAA, 6'd42, 1'b0, NONE_ROW},
      '{bole_pkg::K_POP,    32'h5555_5555, 6'd21, 1'b0, NONE_ROW},
      '{bole_pkg::K_POP,    32'h0000_0000, 6'd0,  1'b0, NONE_ROW},
      '{bole_pkg::K_POP,    32'hFFFF_FFFF, 6'd63, 1'b0, NONE_ROW},
      '{bole_pkg::K_POP,    32'h0000_0000, 6'd0,  1'b1,
        '{bole_pkg::ST_RANGE,    bole_pkg::IDX_NONE, 7'd0, 1'b1}}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // item_value [31:0], position [37:32], zero pad
   logic [1:0]  req_tuser  = '0;   // kind [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // status [1:0], found_index [8:2],
                                   // entry_count [15:9], is_empty [16], zero pad

   // shadow copy of the list, oldest entry first
   logic [bole_pkg::VALUE_W-1:0] shadow_list [$];
   // results predicted for accepted req transfers, oldest first
   list_result_type              pending_results [$];

   int error_count = 0;
   int regime      = GROW;
   int regime_left = 60;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bounded_ordered_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // applies one operation to the shadow list and returns the result it gives
   function automatic list_result_type apply_list_op(
         input logic [bole_pkg::KIND_W-1:0]  kind,
         input logic [bole_pkg::VALUE_W-1:0] item_value,
         input logic [bole_pkg::POS_W-1:0]   position);
      list_result_type r;
      r.status      = bole_pkg::ST_OK;
      r.found_index = bole_pkg::IDX_NONE;
      case (kind)
         bole_pkg::K_APPEND: begin
            if (shadow_list.size() >= bole_pkg::DEPTH) r.status = bole_pkg::ST_FULL;
            else shadow_list.push_back(item_value);
         end
         bole_pkg::K_REMOVE: begin
            if (int'(position) >= shadow_list.size()) r.status = bole_pkg::ST_RANGE;
            else shadow_list.delete(int'(position));
         end
         bole_pkg::K_POP: begin
            if (shadow_list.size() == 0) r.status = bole_pkg::ST_RANGE;
            else void'(shadow_list.pop_back());
         end
         default: begin
            // first match wins
            r.status = bole_pkg::ST_NOTFOUND;
            for (int i = 0; i < shadow_list.size(); i++) begin
               if (r.status == bole_pkg::ST_NOTFOUND && shadow_list[i] == item_value) begin
                  r.status      = bole_pkg::ST_OK;
                  r.found_index = 7'(i);
               end
            end
         end
      endcase
      r.entry_count = 7'(shadow_list.size());
      r.is_empty    = (shadow_list.size() == 0);
      return r;
   endfunction

   // value biased toward the field extremes and toward entries already held
   function automatic logic [bole_pkg::VALUE_W-1:0] pick_value(input int held_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < held_pct && shadow_list.size() != 0)
         return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      if (roll < held_pct + 12) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // random item shaped by the current regime: grow phases mostly append,
   // shrink phases mostly remove and pop, unused fields carry random noise
   task automatic next_random_op(output logic [bole_pkg::KIND_W-1:0]  kind,
                                 output logic [bole_pkg::VALUE_W-1:0] item_value,
                                 output logic [bole_pkg::POS_W-1:0]   position);
      int roll;
      int held;
      roll = $urandom_range(0, 99);
      held = shadow_list.size();
      if (regime_left == 0) begin
         regime      = $urandom_range(GROW, MIXED);
         regime_left = $urandom_range(30, 90);
      end
      regime_left--;
      case (regime)
         GROW:    kind = (roll < 75) ? bole_pkg::K_APPEND :
                         (roll < 83) ? bole_pkg::K_FIND :
                         (roll < 91) ? bole_pkg::K_REMOVE : bole_pkg::K_POP;
         SHRINK:  kind = (roll < 15) ? bole_pkg::K_APPEND :
                         (roll < 35) ? bole_pkg::K_FIND :
                         (roll < 75) ? bole_pkg::K_REMOVE : bole_pkg::K_POP;
         default: kind = (roll < 30) ? bole_pkg::K_APPEND :
                         (roll < 60) ? bole_pkg::K_FIND :
                         (roll < 85) ? bole_pkg::K_REMOVE : bole_pkg::K_POP;
      endcase
      item_value = $urandom;
      position   = $urandom_range(0, 63);
      case (kind)
         bole_pkg::K_APPEND: item_value = pick_value(30);
         bole_pkg::K_FIND:   item_value = pick_value(60);
         bole_pkg::K_REMOVE: begin
            // mostly valid positions with head and tail favored, some past the end
            roll = $urandom_range(0, 99);
            if (held != 0 && roll < 85) begin
               if (roll < 17)      position = '0;
               else if (roll < 34) position = 6'(held - 1);
               else                position = 6'($urandom_range(0, held - 1));
            end
         end
         default: ;
      endcase
   endtask

   // random wait for one side, zero throughout a calm stretch
   function automatic int draw_wait(input logic calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic note_mismatch(input string field, input int expected, input int actual);
      error_count++;
      if (error_count <= 10)
         $display("%0t rsp %s mismatch: expected %0d, got %0d", $realtime, field,
                  expected, actual);
   endtask

   // req side: directed table, then random items; each accepted transfer is
   // predicted right away, well ahead of its rsp
   initial begin
      logic [bole_pkg::KIND_W-1:0]  kind;
      logic [bole_pkg::VALUE_W-1:0] item_value;
      logic [bole_pkg::POS_W-1:0]   position;
      list_result_type              predicted;
      logic                         calm;
      int                           gap;
      calm = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < NUM_DIRECTED + NUM_RANDOM; n++) begin
         if (n < NUM_DIRECTED) begin
            kind       = DIRECTED_OPS[n].kind;
            item_value = DIRECTED_OPS[n].item_value;
            position   = DIRECTED_OPS[n].position;
         end else begin
            next_random_op(kind, item_value, position);
         end
         if ($urandom_range(0, 39) == 0) calm = ~calm;
         gap = draw_wait(calm);
         // a back-to-back item keeps tvalid high, only the payload changes
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {2'b00, position, item_value};
         req_tuser  <= kind;
         do @(posedge clock); while (!req_tready);
         predicted = apply_list_op(kind, item_value, position);
         if (n < NUM_DIRECTED && DIRECTED_OPS[n].has_result)
            pending_results.push_back(DIRECTED_OPS[n].result);
         else
            pending_results.push_back(predicted);
      end
      req_tvalid <= 1'b0;

      // drain, then linger long enough for any stray transfer to show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (bole_pkg::DEPTH + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // rsp side: random stalls before each transfer, compare with the oldest prediction
   initial begin
      list_result_type expected;
      logic            calm;
      int              stall;
      calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) calm = ~calm;
         stall = draw_wait(calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t rsp transfer with no result pending: %h", $realtime,
                        rsp_tdata);
         end else begin
            expected = pending_results.pop_front();
            if (rsp_tdata[1:0] !== expected.status)
               note_mismatch("status", expected.status, rsp_tdata[1:0]);
            if (rsp_tdata[8:2] !== expected.found_index)
               note_mismatch("found_index", $signed(expected.found_index),
                             $signed(rsp_tdata[8:2]));
            if (rsp_tdata[15:9] !== expected.entry_count)
               note_mismatch("entry_count", expected.entry_count, rsp_tdata[15:9]);
            if (rsp_tdata[16] !== expected.is_empty)
               note_mismatch("is_empty", expected.is_empty, rsp_tdata[16]);
         end
      end
   end

   // hang guard, several times the slowest clean run
   initial begin
      #2_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
